// ===== design/assert_macros.svh =====
// Assertion helper macros, included by range_checked_gcd.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NORST(label, prop, msg)
`endif
`endif

// ===== design/rcgcd_pkg.sv =====
package rcgcd_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned MagW   = 31;
  // One binary GCD step per stage: two steps per bit of magnitude, plus two.
  localparam int unsigned NumSteps = 2 * MagW + 2;
  localparam int unsigned ShW    = $clog2(MagW + 1);

  typedef enum logic [1:0] {
    REG_FIRST_LOW   = 2'd0,
    REG_FIRST_HIGH  = 2'd1,
    REG_SECOND_LOW  = 2'd2,
    REG_SECOND_HIGH = 2'd3
  } reg_idx_e;

  localparam logic [DataW-1:0] NumRegs = DataW'(4);

  typedef struct packed {
    logic signed [DataW-1:0] first_value;
    logic signed [DataW-1:0] second_value;
  } in_item_t;

  typedef struct packed {
    logic [MagW-1:0] divisor;
    logic            out_of_range;
  } out_item_t;

  // Working set that travels down the step pipeline.
  typedef struct packed {
    logic [MagW-1:0] a;
    logic [MagW-1:0] b;
    logic [ShW-1:0]  shift;
    logic            active;
    logic            out_of_range;
  } gcd_work_t;

  // One binary GCD step on a working set.
  function automatic gcd_work_t gcd_step(gcd_work_t w);
    gcd_work_t r;
    logic [MagW-1:0] hi;
    logic [MagW-1:0] lo;
    r = w;
    hi = (w.a > w.b) ? w.a : w.b;
    lo = (w.a > w.b) ? w.b : w.a;
    if (w.active && w.b != '0 && w.a != '0) begin
      if (!w.a[0] && !w.b[0]) begin
        r.a = w.a >> 1;
        r.b = w.b >> 1;
        r.shift = w.shift + ShW'(1);
      end else if (!w.a[0]) begin
        r.a = w.a >> 1;
      end else if (!w.b[0]) begin
        r.b = w.b >> 1;
      end else begin
        r.a = lo;
        r.b = (hi - lo) >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/rcgcd_check.sv =====
module rcgcd_check (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [31:0]              cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  input  rcgcd_pkg::in_item_t      item_i,
  output rcgcd_pkg::gcd_work_t     work_o
);
  logic signed [31:0] f_lo_q, f_hi_q, s_lo_q, s_hi_q;
  logic               bad;
  logic               pos;

  // Capture configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_lo_q <= 32'sd1;
      f_hi_q <= 32'sh7fffffff;
      s_lo_q <= 32'sd1;
      s_hi_q <= 32'sh7fffffff;
    end else if (cfg_we_i && cfg_idx_i < rcgcd_pkg::NumRegs) begin
      case (rcgcd_pkg::reg_idx_e'(cfg_idx_i[1:0]))
        rcgcd_pkg::REG_FIRST_LOW:   f_lo_q <= cfg_data_i;
        rcgcd_pkg::REG_FIRST_HIGH:  f_hi_q <= cfg_data_i;
        rcgcd_pkg::REG_SECOND_LOW:  s_lo_q <= cfg_data_i;
        rcgcd_pkg::REG_SECOND_HIGH: s_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Range check and seed the step pipeline.
  always_comb begin
    bad = (item_i.first_value < f_lo_q) || (item_i.first_value > f_hi_q) ||
          (item_i.second_value < s_lo_q) || (item_i.second_value > s_hi_q);
    pos = (item_i.first_value > 0) && (item_i.second_value > 0);
    work_o.a = item_i.first_value[30:0];
    work_o.b = item_i.second_value[30:0];
    work_o.shift = '0;
    work_o.active = !bad && pos;
    work_o.out_of_range = bad;
  end
endmodule

// ===== design/rcgcd_stage.sv =====
module rcgcd_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rcgcd_pkg::gcd_work_t work_i,
  output logic                 valid_o,
  output rcgcd_pkg::gcd_work_t work_o
);
  logic                 valid_q;
  rcgcd_pkg::gcd_work_t work_q;

  // Advance one step when the pipeline moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= rcgcd_pkg::gcd_step(work_i);
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;
endmodule

// ===== design/range_checked_gcd.sv =====
// Range-checked GCD: a fully pipelined binary GCD. Every cycle one operand
// pair may enter while in_stall_o is low; its result passes through 65
// registers (64 binary GCD step stages, the range check folded into the
// first, plus one output register) before it can transfer out. The step
// chain length, two steps per magnitude bit plus two, sets the latency;
// throughput is one transfer per cycle when not stalled. A stall on the
// output freezes the whole chain. Out-of-range pairs give divisor 0 with
// out_of_range set; pairs with an operand below one give divisor 0.
`include "assert_macros.svh"
module range_checked_gcd (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rcgcd_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rcgcd_pkg::out_item_t  out_data_o
);
  localparam int unsigned N = rcgcd_pkg::NumSteps;

  rcgcd_pkg::gcd_work_t work[N+1];
  logic                 vld[N+1];
  logic                 en;
  rcgcd_pkg::gcd_work_t fin;
  logic [rcgcd_pkg::MagW-1:0] res;

  // Move the chain whenever the output slot is empty or being taken.
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign vld[0] = in_valid_i;

  rcgcd_check u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i (in_data_i),
    .work_o (work[0])
  );

  for (genvar s = 0; s < N; s++) begin : g_step
    rcgcd_stage u_stage (
      .clk_i, .rst_ni,
      .en_i    (en),
      .valid_i (vld[s]),
      .work_i  (work[s]),
      .valid_o (vld[s+1]),
      .work_o  (work[s+1])
    );
  end

  // Combine the remaining magnitude and restore common powers of two.
  assign fin = work[N];
  assign res = fin.active ? ((fin.a | fin.b) << fin.shift) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.divisor      <= res;
      out_data_o.out_of_range <= fin.out_of_range;
    end
  end

  `ASSERT_CLK(a_stall_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o),
              "result changed under stall")
  `ASSERT_CLK(a_inv_zero, out_valid_o && out_data_o.out_of_range |-> out_data_o.divisor == '0,
              "out of range result carries nonzero divisor")
  `ASSERT_CLK(a_stall_link, in_stall_o == (out_valid_o && out_stall_i),
              "input stall does not follow output")
  `ASSERT_CLK(a_done, vld[N] && fin.active |-> (fin.a == '0 || fin.b == '0),
              "step chain too short")
endmodule
